// ----- rtl/eik_pkg.sv -----
// shared types and constants for the eikonal distance update pipeline
package eik_pkg;

    // field widths
    localparam int VALUE_BITS   = 32;
    localparam int SPACING_BITS = 21;
    localparam int DIST_BITS    = 31;
    localparam int MAG_BITS     = 32;
    localparam int WIDE_BITS    = 33;
    localparam int NUM_BITS     = 34;

    // square root datapath
    localparam int DIFF_BITS = 22;
    localparam int ROOT_BITS = 22;
    localparam int SQ_BITS   = 44;
    localparam int HH_BITS   = 42;
    localparam int SUM_BITS  = 46;
    localparam int TERM_BITS = 46;

    // divide by three as multiply by reciprocal, split in two partial products
    localparam int                RECIP_SHIFT = 35;
    localparam int                SPLIT_BITS  = 17;
    localparam int                PROD_BITS   = 51;
    localparam int                ACC_BITS    = 68;
    localparam logic [NUM_BITS-1:0] RECIP_THREE = 34'd11453246123;

    // cycles from accepted word to result strobe
    localparam int LATENCY = ROOT_BITS + 10;

    localparam logic [SPACING_BITS-1:0] SPACING_RESET = 21'd65536;

    // axes used codes
    localparam logic [1:0] AXES_ONE   = 2'd1;
    localparam logic [1:0] AXES_TWO   = 2'd2;
    localparam logic [1:0] AXES_THREE = 2'd3;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] x_minus_value;
        logic signed [VALUE_BITS-1:0] x_plus_value;
        logic signed [VALUE_BITS-1:0] y_minus_value;
        logic signed [VALUE_BITS-1:0] y_plus_value;
        logic signed [VALUE_BITS-1:0] z_minus_value;
        logic signed [VALUE_BITS-1:0] z_plus_value;
    } in_word_t;

    typedef struct packed {
        logic [DIST_BITS-1:0] new_distance;
        logic [1:0]           axes_used;
    } out_word_t;

    // per-item values that ride alongside the square root stages
    typedef struct packed {
        logic [MAG_BITS-1:0]  d2;
        logic [WIDE_BITS-1:0] one_res;
        logic                 sel1;
        logic [WIDE_BITS-1:0] s01;
        logic [WIDE_BITS-1:0] s3;
    } side_t;

endpackage

// ----- rtl/eikonal_distance_update.sv -----
// top level: pipelined first-order eikonal update of one grid cell
//
//  channel   signals                      width  direction  notes
//  input     start, busy, cell_in         6x32   in         word taken at start && !busy
//  result    result_valid, result         31+2   out        one-cycle strobe, no back-pressure
//  config    cfg_write, cfg_data          21     in         grid spacing, written at once
//
// one word per clock; each result passes through the pipeline,
// made of the 22 one-bit-per-stage square root stages plus ten arithmetic stages
// reset clears the valid bits and loads the spacing with 1.0
// busy is held low: the pipeline never stalls and the receiver cannot hold results off
module eikonal_distance_update
    import eik_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    cfg_write,
    input  logic [SPACING_BITS-1:0] cfg_data,
    input  in_word_t                cell_in,
    output logic                    result_valid,
    output out_word_t               result
);

    // magnitude of a signed value; the most negative value maps to 2^31
    function automatic logic [MAG_BITS-1:0] mag_of(input logic [VALUE_BITS-1:0] v);
        logic [MAG_BITS-1:0] u;
        u = v;
        return u[MAG_BITS-1] ? (~u + MAG_BITS'(1)) : u;
    endfunction

    function automatic logic [MAG_BITS-1:0] min_of(input logic [MAG_BITS-1:0] a,
                                                   input logic [MAG_BITS-1:0] b);
        return (a < b) ? a : b;
    endfunction

    logic [SPACING_BITS-1:0] spacing_reg;

    logic                    v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic                    vp1_reg, vp2_reg, vp3_reg;
    logic                    result_valid_reg;
    out_word_t               result_reg;
    out_word_t               result_next;

    logic [MAG_BITS-1:0]     ax_reg [3];
    logic [MAG_BITS-1:0]     ax_next [3];
    logic [SPACING_BITS-1:0] h1_reg, h2_reg, h3_reg;

    logic [MAG_BITS-1:0]     d_reg [3];
    logic [MAG_BITS-1:0]     d_next [3];

    logic [DIFF_BITS-1:0]    dif_reg [3];
    logic                    big_reg [3];
    side_t                   side3_reg, side3_next;

    logic [SQ_BITS-1:0]      sq_reg [3];
    logic                    big4_reg [3];
    logic [HH_BITS-1:0]      hh_reg;
    side_t                   side4_reg;

    logic [SUM_BITS-1:0]     sum5_reg;
    logic [SQ_BITS-1:0]      th5_reg;
    logic [HH_BITS:0]        tw5_reg;
    logic [SQ_BITS-1:0]      sq01_5_reg;
    logic                    big01_5_reg, bigany5_reg;
    side_t                   side5_reg;

    logic [SQ_BITS-1:0]      rad2_next, rad3_next;

    logic                    sv_reg    [ROOT_BITS+1];
    side_t                   sside_reg [ROOT_BITS+1];
    logic [ROOT_BITS-1:0]    root2_reg [ROOT_BITS+1];
    logic [SQ_BITS-1:0]      rem2_reg  [ROOT_BITS+1];
    logic [ROOT_BITS-1:0]    root3_reg [ROOT_BITS+1];
    logic [SQ_BITS-1:0]      rem3_reg  [ROOT_BITS+1];

    logic [WIDE_BITS-1:0]    r2p1_reg, r2p2_reg, r2p3_reg;
    logic [NUM_BITS-1:0]     num_reg;
    side_t                   sidep1_reg, sidep2_reg, sidep3_reg;
    logic [PROD_BITS-1:0]    prod_hi_reg, prod_lo_reg;
    logic                    sel2p2_reg, sel2p3_reg;
    logic [WIDE_BITS-1:0]    r3_reg;
    logic [ACC_BITS-1:0]     quot_acc;
    logic [WIDE_BITS-1:0]    pick;

    assign busy = 1'b0;

    // spacing register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spacing_reg <= SPACING_RESET;
        end
        else if (cfg_write)
        begin
            spacing_reg <= cfg_data;
        end
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg           <= 1'b0;
            v2_reg           <= 1'b0;
            v3_reg           <= 1'b0;
            v4_reg           <= 1'b0;
            v5_reg           <= 1'b0;
            sv_reg[0]        <= 1'b0;
            vp1_reg          <= 1'b0;
            vp2_reg          <= 1'b0;
            vp3_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg           <= start && !busy;
            v2_reg           <= v1_reg;
            v3_reg           <= v2_reg;
            v4_reg           <= v3_reg;
            v5_reg           <= v4_reg;
            sv_reg[0]        <= v5_reg;
            vp1_reg          <= sv_reg[ROOT_BITS];
            vp2_reg          <= vp1_reg;
            vp3_reg          <= vp2_reg;
            result_valid_reg <= vp3_reg;
        end
    end

    // stage 1: per-axis smaller magnitude
    always_comb
    begin
        ax_next[0] = min_of(mag_of(cell_in.x_minus_value), mag_of(cell_in.x_plus_value));
        ax_next[1] = min_of(mag_of(cell_in.y_minus_value), mag_of(cell_in.y_plus_value));
        ax_next[2] = min_of(mag_of(cell_in.z_minus_value), mag_of(cell_in.z_plus_value));
    end

    // stage 2: three-way sort from parallel compares
    always_comb
    begin
        logic gt_ab, gt_ac, gt_bc;
        gt_ab = ax_reg[0] > ax_reg[1];
        gt_ac = ax_reg[0] > ax_reg[2];
        gt_bc = ax_reg[1] > ax_reg[2];
        d_next[0] = (!gt_ab && !gt_ac) ? ax_reg[0] : (!gt_bc ? ax_reg[1] : ax_reg[2]);
        d_next[2] = (gt_ab && gt_ac) ? ax_reg[0] : (gt_bc ? ax_reg[1] : ax_reg[2]);
        // the middle is what remains once the min and max values are cancelled
        d_next[1] = ax_reg[0] ^ ax_reg[1] ^ ax_reg[2] ^ d_next[0] ^ d_next[2];
    end

    // stage 3: differences, sums and the one-axis trial
    always_comb
    begin
        side3_next.d2      = d_reg[2];
        side3_next.one_res = WIDE_BITS'(d_reg[0]) + WIDE_BITS'(h2_reg);
        side3_next.sel1    = !(side3_next.one_res > WIDE_BITS'(d_reg[1]));
        side3_next.s01     = WIDE_BITS'(d_reg[0]) + WIDE_BITS'(d_reg[1]);
        side3_next.s3      = side3_next.s01 + WIDE_BITS'(d_reg[2]);
    end

    // stage 6: radicands, clamped at zero
    always_comb
    begin
        if (big01_5_reg || (sq01_5_reg > SQ_BITS'(tw5_reg)))
        begin
            rad2_next = '0;
        end
        else
        begin
            rad2_next = SQ_BITS'(tw5_reg) - sq01_5_reg;
        end
        if (bigany5_reg || (sum5_reg > SUM_BITS'(th5_reg)))
        begin
            rad3_next = '0;
        end
        else
        begin
            rad3_next = th5_reg - sum5_reg[SQ_BITS-1:0];
        end
    end

    // datapath registers of stages 1 to 6
    always_ff @(posedge clk)
    begin
        ax_reg      <= ax_next;
        h1_reg      <= spacing_reg;

        d_reg       <= d_next;
        h2_reg      <= h1_reg;

        dif_reg[0]  <= DIFF_BITS'(d_reg[1] - d_reg[0]);
        dif_reg[1]  <= DIFF_BITS'(d_reg[2] - d_reg[0]);
        dif_reg[2]  <= DIFF_BITS'(d_reg[2] - d_reg[1]);
        big_reg[0]  <= |((d_reg[1] - d_reg[0]) >> DIFF_BITS);
        big_reg[1]  <= |((d_reg[2] - d_reg[0]) >> DIFF_BITS);
        big_reg[2]  <= |((d_reg[2] - d_reg[1]) >> DIFF_BITS);
        h3_reg      <= h2_reg;
        side3_reg   <= side3_next;

        sq_reg[0]   <= SQ_BITS'(dif_reg[0]) * SQ_BITS'(dif_reg[0]);
        sq_reg[1]   <= SQ_BITS'(dif_reg[1]) * SQ_BITS'(dif_reg[1]);
        sq_reg[2]   <= SQ_BITS'(dif_reg[2]) * SQ_BITS'(dif_reg[2]);
        big4_reg    <= big_reg;
        hh_reg      <= HH_BITS'(h3_reg) * HH_BITS'(h3_reg);
        side4_reg   <= side3_reg;

        sum5_reg    <= SUM_BITS'(sq_reg[0]) + SUM_BITS'(sq_reg[1]) + SUM_BITS'(sq_reg[2]);
        tw5_reg     <= {hh_reg, 1'b0};
        th5_reg     <= SQ_BITS'(hh_reg) + SQ_BITS'({hh_reg, 1'b0});
        sq01_5_reg  <= sq_reg[0];
        big01_5_reg <= big4_reg[0];
        bigany5_reg <= big4_reg[0] || big4_reg[1] || big4_reg[2];
        side5_reg   <= side4_reg;

        rem2_reg[0]  <= rad2_next;
        rem3_reg[0]  <= rad3_next;
        root2_reg[0] <= '0;
        root3_reg[0] <= '0;
        sside_reg[0] <= side5_reg;
    end

    // square root stages: one result bit each, both radicands side by side
    for (genvar j = 0; j < ROOT_BITS; j++)
    begin : g_sqrt
        localparam int K = ROOT_BITS - 1 - j;

        logic [TERM_BITS-1:0] term2, term3;
        logic                 take2, take3;
        logic [ROOT_BITS-1:0] root2_next, root3_next;
        logic [SQ_BITS-1:0]   rem2_next, rem3_next;

        always_comb
        begin
            term2 = (TERM_BITS'(root2_reg[j]) << (K + 1)) + (TERM_BITS'(1) << (2 * K));
            term3 = (TERM_BITS'(root3_reg[j]) << (K + 1)) + (TERM_BITS'(1) << (2 * K));
            take2 = TERM_BITS'(rem2_reg[j]) >= term2;
            take3 = TERM_BITS'(rem3_reg[j]) >= term3;
            rem2_next  = take2 ? SQ_BITS'(TERM_BITS'(rem2_reg[j]) - term2) : rem2_reg[j];
            rem3_next  = take3 ? SQ_BITS'(TERM_BITS'(rem3_reg[j]) - term3) : rem3_reg[j];
            root2_next = take2 ? (root2_reg[j] | (ROOT_BITS'(1) << K)) : root2_reg[j];
            root3_next = take3 ? (root3_reg[j] | (ROOT_BITS'(1) << K)) : root3_reg[j];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sv_reg[j+1] <= 1'b0;
            end
            else
            begin
                sv_reg[j+1] <= sv_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            rem2_reg[j+1]  <= rem2_next;
            rem3_reg[j+1]  <= rem3_next;
            root2_reg[j+1] <= root2_next;
            root3_reg[j+1] <= root3_next;
            sside_reg[j+1] <= sside_reg[j];
        end
    end

    // final divide by three and selection
    always_comb
    begin
        quot_acc = (ACC_BITS'(prod_hi_reg) << SPLIT_BITS) + ACC_BITS'(prod_lo_reg);
        if (sidep3_reg.sel1)
        begin
            pick = sidep3_reg.one_res;
            result_next.axes_used = AXES_ONE;
        end
        else if (sel2p3_reg)
        begin
            pick = r2p3_reg;
            result_next.axes_used = AXES_TWO;
        end
        else
        begin
            pick = r3_reg;
            result_next.axes_used = AXES_THREE;
        end
        // saturate at the largest distance
        if (pick[WIDE_BITS-1:DIST_BITS] != '0)
        begin
            result_next.new_distance = '1;
        end
        else
        begin
            result_next.new_distance = pick[DIST_BITS-1:0];
        end
    end

    // post-root stages
    always_ff @(posedge clk)
    begin
        r2p1_reg    <= WIDE_BITS'((NUM_BITS'(sside_reg[ROOT_BITS].s01)
                                   + NUM_BITS'(root2_reg[ROOT_BITS])) >> 1);
        num_reg     <= NUM_BITS'(sside_reg[ROOT_BITS].s3) + NUM_BITS'(root3_reg[ROOT_BITS]);
        sidep1_reg  <= sside_reg[ROOT_BITS];

        prod_hi_reg <= PROD_BITS'(num_reg[NUM_BITS-1:SPLIT_BITS]) * PROD_BITS'(RECIP_THREE);
        prod_lo_reg <= PROD_BITS'(num_reg[SPLIT_BITS-1:0]) * PROD_BITS'(RECIP_THREE);
        sel2p2_reg  <= !(r2p1_reg > WIDE_BITS'(sidep1_reg.d2));
        r2p2_reg    <= r2p1_reg;
        sidep2_reg  <= sidep1_reg;

        r3_reg      <= quot_acc[RECIP_SHIFT +: WIDE_BITS];
        sel2p3_reg  <= sel2p2_reg;
        r2p3_reg    <= r2p2_reg;
        sidep3_reg  <= sidep2_reg;

        result_reg  <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // every accepted word must come out as a result strobe
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY result_valid)
        else $error("result strobe missing after accepted word");

    a_origin: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start && !busy, LATENCY))
        else $error("result strobe without an accepted word");

    a_axes: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.axes_used >= AXES_ONE))
        else $error("axes count zero on a result");

endmodule

// ----- tb/eikonal_distance_checker.sv -----
// checker: predicts the eikonal update for each accepted cell and compares results
module eikonal_distance_checker
    import eik_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic                    busy,
    input  logic                    cfg_write,
    input  logic [SPACING_BITS-1:0] cfg_data,
    input  in_word_t                cell_in,
    input  logic                    result_valid,
    input  out_word_t               result,
    output int                      fail_count,
    output int                      pending_count,
    output int                      checked_count
);

    logic [SPACING_BITS-1:0] spacing_h;
    out_word_t               expected_words[$];

    // magnitude of a signed value, most negative kept exactly
    function automatic logic [63:0] abs_value(logic signed [VALUE_BITS-1:0] v);
        logic [63:0] w;
        w = {{32{v[VALUE_BITS-1]}}, v};
        return v[VALUE_BITS-1] ? (64'd0 - w) : w;
    endfunction

    // floor integer square root
    function automatic logic [63:0] floor_root(logic [63:0] n);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n    = n - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // squared difference, saturated when the difference is huge
    function automatic logic [63:0] diff_square(logic [63:0] a, logic [63:0] b);
        logic [63:0] d;
        d = (a > b) ? a - b : b - a;
        if (d >= 64'd1 << 31)
            return '1;
        return d * d;
    endfunction

    // full cell update for the current spacing
    function automatic out_word_t cell_update(in_word_t c, logic [SPACING_BITS-1:0] hs);
        logic [63:0] a0, a1, a2, t, h, hh, res, dd, rad, s, pos, pa, pb, pc, rad3;
        logic [1:0]  axes;
        out_word_t   w;
        a0 = abs_value(c.x_minus_value) < abs_value(c.x_plus_value) ?
             abs_value(c.x_minus_value) : abs_value(c.x_plus_value);
        a1 = abs_value(c.y_minus_value) < abs_value(c.y_plus_value) ?
             abs_value(c.y_minus_value) : abs_value(c.y_plus_value);
        a2 = abs_value(c.z_minus_value) < abs_value(c.z_plus_value) ?
             abs_value(c.z_minus_value) : abs_value(c.z_plus_value);
        if (a0 > a1)
        begin
            t = a0; a0 = a1; a1 = t;
        end
        if (a1 > a2)
        begin
            t = a1; a1 = a2; a2 = t;
        end
        if (a0 > a1)
        begin
            t = a0; a0 = a1; a1 = t;
        end
        h    = hs;
        hh   = h * h;
        res  = a0 + h;
        axes = AXES_ONE;
        if (res > a1)
        begin
            dd   = diff_square(a1, a0);
            rad  = (2 * hh > dd) ? 2 * hh - dd : 0;
            res  = (a0 + a1 + floor_root(rad)) >> 1;
            axes = AXES_TWO;
            if (res > a2)
            begin
                s    = a0 + a1 + a2;
                pos  = 3 * hh;
                pa   = diff_square(a0, a1);
                pb   = diff_square(a0, a2);
                pc   = diff_square(a1, a2);
                rad3 = 0;
                if (pa <= pos)
                begin
                    pos = pos - pa;
                    if (pb <= pos)
                    begin
                        pos = pos - pb;
                        if (pc <= pos)
                            rad3 = pos - pc;
                    end
                end
                res  = (s + floor_root(rad3)) / 3;
                axes = AXES_THREE;
            end
        end
        if (res > 64'h7FFF_FFFF)
            res = 64'h7FFF_FFFF;
        w.new_distance = res[DIST_BITS-1:0];
        w.axes_used    = axes;
        return w;
    endfunction

    assign pending_count = expected_words.size();

    // track spacing, queue predictions, compare results
    always @(posedge clk or negedge rst_n)
    begin
        out_word_t want;
        if (!rst_n)
        begin
            spacing_h     <= SPACING_RESET;
            fail_count    <= 0;
            checked_count <= 0;
            expected_words.delete();
        end
        else
        begin
            if (result_valid)
            begin
                checked_count <= checked_count + 1;
                if (expected_words.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result word: %0d axes %0d",
                                 result.new_distance, result.axes_used);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (want.new_distance !== result.new_distance ||
                        want.axes_used !== result.axes_used)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: distance exp %0d got %0d, axes exp %0d got %0d",
                                     want.new_distance, result.new_distance,
                                     want.axes_used, result.axes_used);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            // queue the prediction at the tail
            if (start && !busy)
                expected_words.insert(expected_words.size(), cell_update(cell_in, spacing_h));
            if (cfg_write)
                spacing_h <= cfg_data;
        end
    end

endmodule

// ----- tb/tb_eikonal_distance_update.sv -----
// testbench top: drives cells and spacing writes, reports the verdict
module tb_eikonal_distance_update;
    import eik_pkg::*;

    logic                    clk = 0;
    logic                    rst_n = 0;
    logic                    start = 0;
    logic                    busy;
    logic                    cfg_write = 0;
    logic [SPACING_BITS-1:0] cfg_data = '0;
    in_word_t                cell_in = '0;
    logic                    result_valid;
    out_word_t               result;
    int                      fail_count, pending_count, checked_count;
    int                      cells_sent = 0;

    always #4 clk = ~clk;

    eikonal_distance_update u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cfg_write(cfg_write), .cfg_data(cfg_data), .cell_in(cell_in),
        .result_valid(result_valid), .result(result)
    );

    eikonal_distance_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cfg_write(cfg_write), .cfg_data(cfg_data), .cell_in(cell_in),
        .result_valid(result_valid), .result(result),
        .fail_count(fail_count), .pending_count(pending_count),
        .checked_count(checked_count)
    );

    // random neighbour value, biased towards nearby magnitudes
    function automatic logic [31:0] pick_value(int scale);
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0: v = $urandom;
            1: v = 32'h8000_0000;
            2: v = 32'h7FFF_FFFF;
            default: v = $urandom_range(0, scale);
        endcase
        if ($urandom_range(0, 1))
            v = -v;
        return v;
    endfunction

    // one cell word, held until accepted
    task automatic send_cell(in_word_t c, bit gaps);
        int idle;
        if (gaps && $urandom_range(0, 3) == 0)
        begin
            idle = $urandom_range(1, 14);
            start <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        start   <= 1'b1;
        cell_in <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        cells_sent++;
    endtask

    // random cell near the current spacing
    task automatic send_random(int scale, bit gaps);
        in_word_t c;
        c.x_minus_value = pick_value(scale);
        c.x_plus_value  = pick_value(scale);
        c.y_minus_value = pick_value(scale);
        c.y_plus_value  = pick_value(scale);
        c.z_minus_value = pick_value(scale);
        c.z_plus_value  = pick_value(scale);
        send_cell(c, gaps);
    endtask

    // spacing write once the pipeline has drained
    task automatic write_spacing(logic [SPACING_BITS-1:0] h);
        start <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= h;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    initial
    begin
        in_word_t c;
        logic [SPACING_BITS-1:0] spacings[6];
        spacings = '{21'd65536, 21'd1, 21'd1048576, 21'h1FFFFF, 21'd0, 21'd23170};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed cells at reset spacing
        c = '0;                                   send_cell(c, 0);
        c = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000};  send_cell(c, 0);
        c = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};  send_cell(c, 0);
        c = '{32'd0, 32'd5, 32'd100000, 32'd200000, 32'd400000, 32'd900000};
        send_cell(c, 0);
        c = '{32'd10000, -32'd10000, 32'd20000, 32'd30000, 32'd900000, 32'd900000};
        send_cell(c, 0);
        c = '{32'd50000, 32'd60000, -32'd52000, 32'd70000, 32'd51000, 32'd80000};
        send_cell(c, 0);
        c = '{32'd0, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'd1};
        send_cell(c, 0);
        c = '{32'hFFFF_FFFF, 32'd1, 32'h8000_0001, 32'h4000_0000, 32'd3, 32'd2};
        send_cell(c, 0);

        // phases across spacing settings, extremes included
        foreach (spacings[k])
        begin
            write_spacing(spacings[k]);
            repeat (150)
                send_random((spacings[k] == 0) ? 4 : int'(spacings[k]) * 3, 1);
        end
        // closing stretch, back to back
        repeat (140)
            send_random(200000, 0);
        start <= 1'b0;

        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
        $display("sent %0d cells over six spacing settings, %0d result words checked",
                 cells_sent, checked_count);
        if (fail_count == 0 && pending_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
